// File: hw/rtl/pas_pkg.sv
// Package for the point-along-segment block: widths, word types and
// pipeline side-band records. No dependencies.
`default_nettype none

package pas_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    localparam int TRAV_BITS = COORD_BITS + 1 + FRAC_BITS;   // travel and segment length
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;            // dx^2 + dy^2
    localparam int RAD_BITS  = 2 * TRAV_BITS;                 // radicand, even width
    localparam int REM_BITS  = TRAV_BITS + 2;                 // square root remainder
    localparam int PROD_BITS = COORD_BITS + TRAV_BITS + 3;    // start*len + delta*travel
    localparam int NUM_BITS  = PROD_BITS + 2;                 // 2*|num| + len
    localparam int QUO_BITS  = COORD_BITS + 1;                // rounded magnitude
    localparam int DREM_BITS = TRAV_BITS + 1;                 // divider remainder, 2*len

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [TRAV_BITS-1:0]  travel;
    } seg_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         clamped;
    } pt_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS:0]   dx;
        logic signed [COORD_BITS:0]   dy;
        logic        [TRAV_BITS-1:0]  travel;
    } side_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         clamped;
        logic                         neg_x;
        logic                         neg_y;
    } div_meta_t;

endpackage

`default_nettype wire

// File: hw/rtl/pas_sqrt_cell.sv
// One digit cell of the pipelined restoring square root.
// Depends on pas_pkg.
`default_nettype none

module pas_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [pas_pkg::REM_BITS-1:0]  rem_in,
    input  wire logic [pas_pkg::TRAV_BITS-1:0] root_in,
    input  wire logic [pas_pkg::RAD_BITS-1:0]  rad_in,
    output logic      [pas_pkg::REM_BITS-1:0]  rem_out,
    output logic      [pas_pkg::TRAV_BITS-1:0] root_out,
    output logic      [pas_pkg::RAD_BITS-1:0]  rad_out
);
    import pas_pkg::*;

    logic [REM_BITS+1:0]  cur;
    logic [REM_BITS+1:0]  trial;
    logic                 fit;
    logic [REM_BITS-1:0]  rem_reg;
    logic [TRAV_BITS-1:0] root_reg;
    logic [RAD_BITS-1:0]  rad_reg;

    // bring down the next two radicand bits and try root*4+1
    always_comb
    begin
        cur   = {rem_in, rad_in[RAD_BITS-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        fit   = (cur >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fit ? REM_BITS'(cur - trial) : REM_BITS'(cur);
            root_reg <= {root_in[TRAV_BITS-2:0], fit};
            rad_reg  <= rad_in << 2;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pas_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
// Depends on pas_pkg.
`default_nettype none

module pas_div_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [pas_pkg::DREM_BITS-1:0] den,
    input  wire logic [pas_pkg::DREM_BITS-1:0] rem_in,
    input  wire logic [pas_pkg::QUO_BITS-1:0]  num_in,
    input  wire logic [pas_pkg::QUO_BITS-1:0]  quo_in,
    output logic      [pas_pkg::DREM_BITS-1:0] rem_out,
    output logic      [pas_pkg::QUO_BITS-1:0]  num_out,
    output logic      [pas_pkg::QUO_BITS-1:0]  quo_out
);
    import pas_pkg::*;

    logic [DREM_BITS:0]   cur;
    logic                 fit;
    logic [DREM_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]  num_reg;
    logic [QUO_BITS-1:0]  quo_reg;

    // shift in the next dividend bit, subtract the divisor where it fits
    always_comb
    begin
        cur = {rem_in, num_in[QUO_BITS-1]};
        fit = (cur >= {1'b0, den});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fit ? DREM_BITS'(cur - {1'b0, den}) : DREM_BITS'(cur);
            num_reg <= num_in << 1;
            quo_reg <= {quo_in[QUO_BITS-2:0], fit};
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/point_along_segment_top.sv
// Top level of the point-along-segment block: front end, square root cell
// chain, product stage, divider cell chains and output register. Uses pas_pkg.
//
//   channel | direction | handshake           | word
//   seg     | in        | seg_valid/seg_stall | seg_word_t (start, end, travel)
//   pt      | out       | pt_valid/pt_stall   | pt_word_t  (point, clamped)
//
// One word enters per cycle while the output is not stalled, and passes through
// the front end, one square root cell per length bit, products and rounding
// setup, one divider cell per quotient bit and the output register.
// Reset clears only the valid bits; there is no kept state between words.
// A stalled output holds the whole pipeline, so seg_stall follows pt_stall
// while a result waits; every stage freezes, empty slots included.
`default_nettype none

module point_along_segment_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               seg_valid,
    output logic                    seg_stall,
    input  wire pas_pkg::seg_word_t seg,
    output logic                    pt_valid,
    input  wire logic               pt_stall,
    output pas_pkg::pt_word_t       pt
);
    import pas_pkg::*;

    logic en;

    // front end
    logic                      a_valid_reg;
    side_t                     a_side_reg;
    logic                      b_valid_reg;
    side_t                     b_side_reg;
    logic [2*COORD_BITS-1:0]   b_sqx_reg;
    logic [2*COORD_BITS-1:0]   b_sqy_reg;
    logic                      c_valid_reg;
    side_t                     c_side_reg;
    logic [SQ_BITS-1:0]        c_sq_reg;
    logic [COORD_BITS-1:0]     adx;
    logic [COORD_BITS-1:0]     ady;

    // square root chain
    logic                      s_valid_reg [0:TRAV_BITS-1];
    side_t                     s_side_reg  [0:TRAV_BITS-1];
    logic [REM_BITS-1:0]       s_rem       [0:TRAV_BITS-1];
    logic [TRAV_BITS-1:0]      s_root      [0:TRAV_BITS-1];
    logic [RAD_BITS-1:0]       s_rad       [0:TRAV_BITS-1];
    logic [TRAV_BITS-1:0]      len;
    side_t                     s_last;

    // products
    logic                                m_valid_reg;
    logic                                m_clamp_reg;
    logic signed [COORD_BITS-1:0]        m_ex_reg;
    logic signed [COORD_BITS-1:0]        m_ey_reg;
    logic        [TRAV_BITS-1:0]         m_len_reg;
    logic signed [COORD_BITS+TRAV_BITS:0]   m_sxl_reg;
    logic signed [COORD_BITS+TRAV_BITS:0]   m_syl_reg;
    logic signed [COORD_BITS+TRAV_BITS+1:0] m_dxt_reg;
    logic signed [COORD_BITS+TRAV_BITS+1:0] m_dyt_reg;

    // rounding setup
    logic                      n_valid_reg;
    div_meta_t                 n_meta_reg;
    logic [NUM_BITS-1:0]       n_numx_reg;
    logic [NUM_BITS-1:0]       n_numy_reg;
    logic [DREM_BITS-1:0]      n_den_reg;
    logic signed [PROD_BITS-1:0] sumx;
    logic signed [PROD_BITS-1:0] sumy;
    logic [PROD_BITS-1:0]      magx;
    logic [PROD_BITS-1:0]      magy;

    // divider chains
    logic                      d_valid_reg [0:QUO_BITS-1];
    div_meta_t                 d_meta_reg  [0:QUO_BITS-1];
    logic [DREM_BITS-1:0]      d_den_reg   [0:QUO_BITS-1];
    logic [DREM_BITS-1:0]      d_rx        [0:QUO_BITS-1];
    logic [DREM_BITS-1:0]      d_ry        [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]       d_nx        [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]       d_ny        [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]       d_qx        [0:QUO_BITS-1];
    logic [QUO_BITS-1:0]       d_qy        [0:QUO_BITS-1];
    div_meta_t                 d_last;

    // output
    logic                      pt_valid_reg;
    pt_word_t                  pt_reg;
    pt_word_t                  pt_next;

    // advance everything unless a finished result is held
    assign en        = !pt_valid_reg || !pt_stall;
    assign seg_stall = !en;

    //------------------------------------------------------------------
    // Front end: deltas, squares, sum of squares
    //------------------------------------------------------------------
    always_comb
    begin
        adx = a_side_reg.dx[COORD_BITS] ? COORD_BITS'(-a_side_reg.dx)
                                        : COORD_BITS'(a_side_reg.dx);
        ady = a_side_reg.dy[COORD_BITS] ? COORD_BITS'(-a_side_reg.dy)
                                        : COORD_BITS'(a_side_reg.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= seg_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg.start_x <= seg.start_x;
            a_side_reg.start_y <= seg.start_y;
            a_side_reg.end_x   <= seg.end_x;
            a_side_reg.end_y   <= seg.end_y;
            a_side_reg.travel  <= seg.travel;
            a_side_reg.dx      <= (COORD_BITS+1)'(seg.end_x) - (COORD_BITS+1)'(seg.start_x);
            a_side_reg.dy      <= (COORD_BITS+1)'(seg.end_y) - (COORD_BITS+1)'(seg.start_y);
            b_side_reg         <= a_side_reg;
            b_sqx_reg          <= adx * adx;
            b_sqy_reg          <= ady * ady;
            c_side_reg         <= b_side_reg;
            c_sq_reg           <= SQ_BITS'(b_sqx_reg) + SQ_BITS'(b_sqy_reg);
        end
    end

    //------------------------------------------------------------------
    // Square root: one cell per length bit
    //------------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < TRAV_BITS; k++)
        begin : g_sqrt
            logic [REM_BITS-1:0]  rem_in;
            logic [TRAV_BITS-1:0] root_in;
            logic [RAD_BITS-1:0]  rad_in;
            logic                 valid_in;
            side_t                side_in;

            if (k == 0)
            begin : g_first
                assign rem_in   = '0;
                assign root_in  = '0;
                assign rad_in   = RAD_BITS'(c_sq_reg) << (2 * FRAC_BITS);
                assign valid_in = c_valid_reg;
                assign side_in  = c_side_reg;
            end
            else
            begin : g_next
                assign rem_in   = s_rem[k-1];
                assign root_in  = s_root[k-1];
                assign rad_in   = s_rad[k-1];
                assign valid_in = s_valid_reg[k-1];
                assign side_in  = s_side_reg[k-1];
            end

            pas_sqrt_cell u_cell (
                .clk      (clk),
                .en       (en),
                .rem_in   (rem_in),
                .root_in  (root_in),
                .rad_in   (rad_in),
                .rem_out  (s_rem[k]),
                .root_out (s_root[k]),
                .rad_out  (s_rad[k])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    s_valid_reg[k] <= 1'b0;
                else if (en)
                    s_valid_reg[k] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    s_side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign len    = s_root[TRAV_BITS-1];
    assign s_last = s_side_reg[TRAV_BITS-1];

    //------------------------------------------------------------------
    // Products start*len and delta*travel, clamp decision
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= s_valid_reg[TRAV_BITS-1];
            n_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_clamp_reg <= (len == '0) || (s_last.travel > len);
            m_ex_reg    <= s_last.end_x;
            m_ey_reg    <= s_last.end_y;
            m_len_reg   <= len;
            m_sxl_reg   <= s_last.start_x * $signed({1'b0, len});
            m_syl_reg   <= s_last.start_y * $signed({1'b0, len});
            m_dxt_reg   <= s_last.dx * $signed({1'b0, s_last.travel});
            m_dyt_reg   <= s_last.dy * $signed({1'b0, s_last.travel});
        end
    end

    //------------------------------------------------------------------
    // Sign and magnitude; dividend 2*|num| + len over divisor 2*len
    //------------------------------------------------------------------
    always_comb
    begin
        sumx = PROD_BITS'(m_sxl_reg) + PROD_BITS'(m_dxt_reg);
        sumy = PROD_BITS'(m_syl_reg) + PROD_BITS'(m_dyt_reg);
        magx = sumx[PROD_BITS-1] ? PROD_BITS'(-sumx) : PROD_BITS'(sumx);
        magy = sumy[PROD_BITS-1] ? PROD_BITS'(-sumy) : PROD_BITS'(sumy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_meta_reg.end_x   <= m_ex_reg;
            n_meta_reg.end_y   <= m_ey_reg;
            n_meta_reg.clamped <= m_clamp_reg;
            n_meta_reg.neg_x   <= sumx[PROD_BITS-1];
            n_meta_reg.neg_y   <= sumy[PROD_BITS-1];
            n_numx_reg         <= {1'b0, magx, 1'b0} + NUM_BITS'(m_len_reg);
            n_numy_reg         <= {1'b0, magy, 1'b0} + NUM_BITS'(m_len_reg);
            n_den_reg          <= {m_len_reg, 1'b0};
        end
    end

    //------------------------------------------------------------------
    // Divider: one cell per quotient bit, one chain per coordinate.
    // The high dividend part is below the divisor whenever the result
    // is used, so it seeds the remainder directly.
    //------------------------------------------------------------------
    generate
        for (k = 0; k < QUO_BITS; k++)
        begin : g_div
            logic [DREM_BITS-1:0] den_in;
            logic [DREM_BITS-1:0] rx_in;
            logic [DREM_BITS-1:0] ry_in;
            logic [QUO_BITS-1:0]  nx_in;
            logic [QUO_BITS-1:0]  ny_in;
            logic [QUO_BITS-1:0]  qx_in;
            logic [QUO_BITS-1:0]  qy_in;
            logic                 valid_in;
            div_meta_t            meta_in;

            if (k == 0)
            begin : g_first
                assign den_in   = n_den_reg;
                assign rx_in    = DREM_BITS'(n_numx_reg >> QUO_BITS);
                assign ry_in    = DREM_BITS'(n_numy_reg >> QUO_BITS);
                assign nx_in    = n_numx_reg[QUO_BITS-1:0];
                assign ny_in    = n_numy_reg[QUO_BITS-1:0];
                assign qx_in    = '0;
                assign qy_in    = '0;
                assign valid_in = n_valid_reg;
                assign meta_in  = n_meta_reg;
            end
            else
            begin : g_next
                assign den_in   = d_den_reg[k-1];
                assign rx_in    = d_rx[k-1];
                assign ry_in    = d_ry[k-1];
                assign nx_in    = d_nx[k-1];
                assign ny_in    = d_ny[k-1];
                assign qx_in    = d_qx[k-1];
                assign qy_in    = d_qy[k-1];
                assign valid_in = d_valid_reg[k-1];
                assign meta_in  = d_meta_reg[k-1];
            end

            pas_div_cell u_cell_x (
                .clk     (clk),
                .en      (en),
                .den     (den_in),
                .rem_in  (rx_in),
                .num_in  (nx_in),
                .quo_in  (qx_in),
                .rem_out (d_rx[k]),
                .num_out (d_nx[k]),
                .quo_out (d_qx[k])
            );

            pas_div_cell u_cell_y (
                .clk     (clk),
                .en      (en),
                .den     (den_in),
                .rem_in  (ry_in),
                .num_in  (ny_in),
                .quo_in  (qy_in),
                .rem_out (d_ry[k]),
                .num_out (d_ny[k]),
                .quo_out (d_qy[k])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    d_valid_reg[k] <= 1'b0;
                else if (en)
                    d_valid_reg[k] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_meta_reg[k] <= meta_in;
                    d_den_reg[k]  <= den_in;
                end
            end
        end
    endgenerate

    assign d_last = d_meta_reg[QUO_BITS-1];

    //------------------------------------------------------------------
    // Output: restore sign, or drop in the end point when clamped
    //------------------------------------------------------------------
    always_comb
    begin
        pt_next.clamped = d_last.clamped;
        if (d_last.clamped)
        begin
            pt_next.point_x = d_last.end_x;
            pt_next.point_y = d_last.end_y;
        end
        else
        begin
            pt_next.point_x = d_last.neg_x ? COORD_BITS'(-d_qx[QUO_BITS-1])
                                           : COORD_BITS'(d_qx[QUO_BITS-1]);
            pt_next.point_y = d_last.neg_y ? COORD_BITS'(-d_qy[QUO_BITS-1])
                                           : COORD_BITS'(d_qy[QUO_BITS-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_valid_reg <= 1'b0;
        else if (en)
            pt_valid_reg <= d_valid_reg[QUO_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pt_reg <= pt_next;
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

`ifndef NO_ASSERTIONS
    // square root remainder never exceeds twice the root
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg[TRAV_BITS-1] |->
            (s_rem[TRAV_BITS-1] <= REM_BITS'({s_root[TRAV_BITS-1], 1'b0})))
        else $error("square root remainder out of bound");

    // an unclamped word leaves the divider with remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg[QUO_BITS-1] && !d_last.clamped) |->
            (d_rx[QUO_BITS-1] < d_den_reg[QUO_BITS-1] &&
             d_ry[QUO_BITS-1] < d_den_reg[QUO_BITS-1]))
        else $error("divider remainder not below divisor");

    // a zero length always takes the clamp path
    assert property (@(posedge clk) disable iff (!rst_n)
        (n_valid_reg && n_den_reg == '0) |-> n_meta_reg.clamped)
        else $error("zero length word not clamped");

    // input is only held back behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall |-> (pt_valid && pt_stall))
        else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire
